// ===== sv/lphs_pkg.sv =====
package lphs_pkg;

    // fixed field widths
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 10;
    // home slot is taken from the key shifted right by this many bits
    localparam int KEY_SHIFT = 4;

    // request actions; the unused code behaves as a lookup
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_SPARE  = 2'd3
    } action_t;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 3'd0,
        STATUS_PRESENT   = 3'd1,
        STATUS_NOT_FOUND = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_NULL      = 3'd4
    } status_t;

    // per-slot marks
    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

    // which slot goes into the response
    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_PROBE = 2'd1,
        SEL_DEL   = 2'd2
    } slot_sel_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic      clear;
        logic      load;
        logic      probe_start;
        logic      probe_step;
        logic      finish;
        status_t   res_status;
        slot_sel_t res_slot;
        logic      wr_en;
        logic      wr_key;
        logic      wr_at_del;
        mark_t     wr_mark;
    } lphs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic home_ready;
        logic out_free;
        logic key_null;
        logic is_insert;
        logic is_remove;
        logic hit;
        logic empty;
        logic del_any;
        logic last;
    } lphs_sts_t;

endpackage

// ===== sv/lphs_if.sv =====
interface lphs_req_if #(
    parameter int KEY_BITS = 48
);
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface lphs_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [9:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== sv/lphs_home.sv =====
module lphs_home
    import lphs_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 48,
    localparam int IW         = $clog2(TABLE_SLOTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [KEY_BITS-1:0] key,
    output logic [IW-1:0]       home,
    output logic                ready
);

    localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam int SW   = KEY_BITS - KEY_SHIFT;
    localparam int DW   = 4;
    localparam int ND   = (SW + DW - 1) / DW;
    localparam int PW   = ND * DW;
    localparam int CW   = $clog2(ND + 1);

    generate
        if (POW2)
        begin : g_mask
            // power-of-two table: the modulo is a mask
            logic [KEY_BITS-1:0] key_reg;

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    key_reg <= key;
                end
            end

            assign home  = IW'(key_reg >> KEY_SHIFT);
            assign ready = 1'b1;
        end
        else
        begin : g_rem
            // remainder four key bits per cycle, msb first
            logic [PW-1:0]    div_reg;
            logic [IW-1:0]    rem_reg;
            logic [CW-1:0]    cnt_reg;
            logic [IW+DW-1:0] trial;
            logic [IW-1:0]    rem_next;

            assign trial = {rem_reg, div_reg[PW-1 -: DW]};

            // take off the largest multiple of the table size that fits
            always_comb
            begin
                rem_next = IW'(trial);
                for (int m = 1; m < (1 << DW); m++)
                begin
                    if (trial >= (IW + DW)'(m * TABLE_SLOTS))
                    begin
                        rem_next = IW'(trial - (IW + DW)'(m * TABLE_SLOTS));
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= '0;
                end
                else if (load)
                begin
                    cnt_reg <= CW'(ND);
                end
                else if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    div_reg <= PW'(key >> KEY_SHIFT);
                    rem_reg <= '0;
                end
                else if (cnt_reg != '0)
                begin
                    div_reg <= {div_reg[PW-DW-1:0], {DW{1'b0}}};
                    rem_reg <= rem_next;
                end
            end

            assign home  = rem_reg;
            assign ready = (cnt_reg == '0);
        end
    endgenerate

endmodule

// ===== sv/lphs_datapath.sv =====
module lphs_datapath
    import lphs_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lphs_cmd_t           cmd,
    output lphs_sts_t           sts,
    input  logic [1:0]          in_action,
    input  logic [KEY_BITS-1:0] in_key,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          out_status,
    output logic [SLOT_W-1:0]   out_slot
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    // request registers
    action_t             action_reg;
    logic [KEY_BITS-1:0] key_reg;

    // probe state
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] cnt_reg;
    logic          have_del_reg;
    logic [IW-1:0] first_del_reg;
    logic [IW-1:0] clr_idx_reg;

    // result register
    logic              out_valid_reg;
    status_t           status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    // table storage
    logic [KEY_BITS-1:0] key_mem  [TABLE_SLOTS];
    mark_t               mark_mem [TABLE_SLOTS];
    logic [KEY_BITS-1:0] key_q;
    mark_t               mark_q;

    logic [IW-1:0] home;
    logic          home_ready;
    logic [IW-1:0] nxt_idx;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] del_slot;
    logic          cur_deleted;
    logic          mark_we;
    mark_t         mark_wdata;

    // home slot unit
    lphs_home #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.load),
        .key   (in_key),
        .home  (home),
        .ready (home_ready)
    );

    // address selection
    assign nxt_idx     = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign rd_addr     = cmd.probe_start ? home : nxt_idx;
    assign cur_deleted = (mark_q == MARK_DELETED);
    assign del_slot    = have_del_reg ? first_del_reg : idx_reg;
    assign wr_addr     = cmd.clear ? clr_idx_reg : (cmd.wr_at_del ? del_slot : idx_reg);
    assign mark_we     = cmd.clear || cmd.wr_en;
    assign mark_wdata  = cmd.clear ? MARK_EMPTY : cmd.wr_mark;

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[wr_addr] <= mark_wdata;
        end
        if (cmd.wr_en && cmd.wr_key)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        mark_q <= mark_mem[rd_addr];
        key_q  <= key_mem[rd_addr];
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // request and probe payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(in_action);
            key_reg    <= in_key;
        end
        if (cmd.probe_start)
        begin
            idx_reg <= home;
            cnt_reg <= '0;
        end
        else if (cmd.probe_step)
        begin
            idx_reg <= nxt_idx;
            cnt_reg <= cnt_reg + 1'b1;
            if (cur_deleted && !have_del_reg)
            begin
                first_del_reg <= idx_reg;
            end
        end
    end

    // first deleted slot seen on this probe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_del_reg <= 1'b0;
        end
        else if (cmd.probe_start)
        begin
            have_del_reg <= 1'b0;
        end
        else if (cmd.probe_step && cur_deleted)
        begin
            have_del_reg <= 1'b1;
        end
    end

    // response slot selection
    always_comb
    begin
        case (cmd.res_slot)
            SEL_PROBE: slot_next = SLOT_W'(idx_reg);
            SEL_DEL:   slot_next = SLOT_W'(del_slot);
            default:   slot_next = '0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= cmd.res_status;
            slot_reg   <= slot_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_slot   = slot_reg;

    // status to controller
    assign sts.clear_last = (clr_idx_reg == LAST_IDX);
    assign sts.home_ready = home_ready;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.key_null   = (key_reg == '0);
    assign sts.is_insert  = (action_reg == ACT_INSERT);
    assign sts.is_remove  = (action_reg == ACT_REMOVE);
    assign sts.hit        = (mark_q == MARK_USED) && (key_q == key_reg);
    assign sts.empty      = (mark_q == MARK_EMPTY);
    assign sts.del_any    = have_del_reg || cur_deleted;
    assign sts.last       = (cnt_reg == LAST_IDX);

endmodule

// ===== sv/lphs_ctrl.sv =====
module lphs_ctrl
    import lphs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_fire,
    output logic      req_ready,
    input  lphs_sts_t sts,
    output lphs_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.res_status = STATUS_NOT_FOUND;
        cmd.res_slot   = SEL_NONE;
        cmd.wr_mark    = MARK_EMPTY;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end

            ST_HASH:
            begin
                // start only once the home slot is ready and the output register can take the result
                if (sts.out_free && sts.home_ready)
                begin
                    if (sts.key_null)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.res_status = STATUS_NULL;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.probe_start = 1'b1;
                        state_next      = ST_PROBE;
                    end
                end
            end

            ST_PROBE:
            begin
                if (sts.hit)
                begin
                    cmd.finish   = 1'b1;
                    cmd.res_slot = SEL_PROBE;
                    state_next   = ST_IDLE;
                    if (sts.is_insert)
                    begin
                        cmd.res_status = STATUS_PRESENT;
                    end
                    else
                    begin
                        cmd.res_status = STATUS_DONE;
                        if (sts.is_remove)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_mark = MARK_DELETED;
                        end
                    end
                end
                else if (sts.empty || sts.last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                    // insert takes the first deleted slot, else this empty one
                    if (sts.is_insert && (sts.empty || sts.del_any))
                    begin
                        cmd.res_status = STATUS_DONE;
                        cmd.res_slot   = SEL_DEL;
                        cmd.wr_en      = 1'b1;
                        cmd.wr_key     = 1'b1;
                        cmd.wr_at_del  = 1'b1;
                        cmd.wr_mark    = MARK_USED;
                    end
                    else if (sts.is_insert)
                    begin
                        cmd.res_status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.res_status = STATUS_NOT_FOUND;
                    end
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/linear_probe_hash_set.sv =====
// Hash set of nonzero keys in an open-addressed table of TABLE_SLOTS slots with
// linear probing and deleted marks. A request carries an action (lookup,
// insert, remove) and a key; each request gives exactly one response with a
// status and a slot. One request is handled at a time: it is accepted, its home
// slot is found, then the table is probed slot by slot from the home slot. The
// probe walk reads the key and mark memories once per cycle; that single read
// port sets the rate. When TABLE_SLOTS is not a power of two the home slot is
// found by a remainder unit that takes four key bits per cycle. A finished
// response sits in an output register while the next request is accepted;
// probing of that request waits until the register is free. After reset the
// block clears the slot marks, one slot per cycle, and accepts no request
// until every slot mark has been cleared.
module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 48
) (
    input logic       clk,
    input logic       rst_n,
    lphs_req_if.sink  req,
    lphs_rsp_if.source rsp
);

    lphs_cmd_t cmd;
    lphs_sts_t sts;
    logic      req_ready;

    assign req.ready = req_ready;

    // controller
    lphs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_fire  (req.valid && req_ready),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    lphs_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_action  (req.action),
        .in_key     (req.key),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_slot   (rsp.slot)
    );

endmodule

// ===== sv/lphs_checker.sv =====
module lphs_checker
    import lphs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [SLOT_W-1:0] rsp_slot
);

    // one request at a time: no accept right after an accept
    a_one_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready
    ) else $error("request accepted while another is in flight");

    // status codes stay in the defined set
    a_status_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_PRESENT ||
                       rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_FULL ||
                       rsp_status == STATUS_NULL)
    ) else $error("undefined response status");

    // no slot is reported when nothing was matched or written
    a_slot_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_FULL ||
                       rsp_status == STATUS_NULL)) |-> (rsp_slot == '0)
    ) else $error("slot reported on a miss");

    // a stalled response holds
    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
    ) else $error("response changed while stalled");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_slot   (rsp.slot)
);
